FILE: design/tksl_pkg.sv
// Package for the top-k score list: field widths, operation and status codes,
// controller states and the entry and cell control structs.
// No dependencies.
package tksl_pkg;

  localparam int TAG_W   = 16;
  localparam int SCORE_W = 32;
  localparam int RANK_W  = 6;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_DUP     = 3'd1,
    ST_DROPPED = 3'd2,
    ST_COUNTED = 3'd3,
    ST_FLUSHED = 3'd4,
    ST_EMPTY   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_FLUSH
  } state_t;

  // One ranked list entry as held by a cell
  typedef struct packed {
    logic                      valid;
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // Broadcast control from the controller to every cell
  typedef struct packed {
    logic                      cmp;        // latch compare flags against tag/score
    logic                      apply;      // perform insert or append
    logic                      append;     // no cell hit: first empty cell takes candidate
    logic                      shift_out;  // flush: move entries toward rank 0
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
  } cell_ctrl_t;

endpackage

FILE: design/tksl_cell.sv
// One cell of the ranked list chain: holds an entry, latches its compare
// flags, and takes data from its left or right neighbor.
// Depends on tksl_pkg.
module tksl_cell (
  input  logic                clk,
  input  logic                rst,
  input  tksl_pkg::cell_ctrl_t ctrl,
  input  tksl_pkg::entry_t    left,
  input  tksl_pkg::entry_t    right,
  input  logic                hit_before_in,
  input  logic                ins_before_in,
  output logic                hit_before_out,
  output logic                ins_before_out,
  output tksl_pkg::entry_t    ent
);

  logic eq;
  logic gt;
  logic ins_here;
  logic take_cand;

  // Latch compare flags while the candidate sits on the ports
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      eq <= ent.valid && (ent.tag == ctrl.tag);
      gt <= ent.valid && ($signed(ctrl.score) > $signed(ent.score));
    end
  end

  // Scan chain: first hit decides; an equal tag there means duplicate
  always_comb begin
    ins_here       = gt && !eq && !hit_before_in;
    hit_before_out = hit_before_in || eq || gt;
    ins_before_out = ins_before_in || ins_here;
    take_cand      = ins_here || (ctrl.append && !ent.valid && left.valid);
  end

  // Shift out on flush, insert or shift right on apply, else hold
  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (ctrl.shift_out) begin
      ent <= right;
    end else if (ctrl.apply) begin
      if (take_cand) begin
        ent.valid <= 1'b1;
        ent.tag   <= ctrl.tag;
        ent.score <= ctrl.score;
      end else if (ins_before_in) begin
        ent <= left;
      end
    end
  end

endmodule

FILE: design/top_k_score_list.sv
// Top level of the top-k score list: controller, running totals, result
// register and a chain of LIST_DEPTH tksl_cell instances.
// Depends on tksl_pkg and tksl_cell.
//
//   port group     direction  transfer when          fields
//   command        in         start && !busy         operation, has_candidate, cand_tag,
//                                                    cand_score, is_spliced, add_count
//   result         out        strobe (one cycle)     status, out_tag, out_score, out_rank,
//                                                    unspliced_sum, spliced_sum, last
//
// An insert has an accept cycle, where every cell compares the candidate in
// parallel, and an apply cycle that resolves the scan along the cell chain and
// updates the list. Its result strobes in the following cycle, while the next
// command may already be accepted.
// A flush keeps busy high until its last entry has shifted out, one entry
// leaving cell 0 per cycle; an empty flush gives a single ST_EMPTY result.
// Reset (rst, synchronous) empties the list and clears both totals.
// Results cannot be stalled; each is presented for exactly one cycle.
module top_k_score_list #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic                                has_candidate,
  input  logic [tksl_pkg::TAG_W-1:0]          cand_tag,
  input  logic signed [tksl_pkg::SCORE_W-1:0] cand_score,
  input  logic                                is_spliced,
  input  logic [tksl_pkg::CNT_W-1:0]          add_count,
  output logic                                strobe,
  output logic [2:0]                          status,
  output logic [tksl_pkg::TAG_W-1:0]          out_tag,
  output logic signed [tksl_pkg::SCORE_W-1:0] out_score,
  output logic [tksl_pkg::RANK_W-1:0]         out_rank,
  output logic [tksl_pkg::SUM_W-1:0]          unspliced_sum,
  output logic [tksl_pkg::SUM_W-1:0]          spliced_sum,
  output logic                                last
);

  tksl_pkg::state_t   state;
  tksl_pkg::state_t   state_next;
  tksl_pkg::cell_ctrl_t ctrl;

  tksl_pkg::entry_t   ent      [LIST_DEPTH];
  tksl_pkg::entry_t   left_ent [LIST_DEPTH];
  tksl_pkg::entry_t   right_ent[LIST_DEPTH];
  logic [LIST_DEPTH:0] hit_chain;
  logic [LIST_DEPTH:0] ins_chain;
  logic [LIST_DEPTH-1:0] valid_vec;

  logic                                accept;
  logic                                cand_has;
  logic [tksl_pkg::TAG_W-1:0]          cand_tag_q;
  logic signed [tksl_pkg::SCORE_W-1:0] cand_score_q;
  logic [tksl_pkg::SUM_W-1:0]          unspliced_total;
  logic [tksl_pkg::SUM_W-1:0]          spliced_total;
  logic [tksl_pkg::SUM_W:0]            sum_wide;
  logic [tksl_pkg::SUM_W-1:0]          sum_sat;
  logic [tksl_pkg::RANK_W-1:0]         rank;
  logic                                list_full;
  logic                                flush_last;
  tksl_pkg::status_t                   apply_status;

  assign accept     = start && !busy;
  assign list_full  = ent[LIST_DEPTH-1].valid;
  assign flush_last = !right_ent[0].valid;

  // Build the cell chain
  assign hit_chain[0] = 1'b0;
  assign ins_chain[0] = 1'b0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_ent[i] = '{valid: 1'b1, tag: '0, score: '0};
    end else begin : g_body
      assign left_ent[i] = ent[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_tail
      assign right_ent[i] = '0;
    end else begin : g_inner
      assign right_ent[i] = ent[i+1];
    end
    assign valid_vec[i] = ent[i].valid;

    tksl_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .left           (left_ent[i]),
      .right          (right_ent[i]),
      .hit_before_in  (hit_chain[i]),
      .ins_before_in  (ins_chain[i]),
      .hit_before_out (hit_chain[i+1]),
      .ins_before_out (ins_chain[i+1]),
      .ent            (ent[i])
    );
  end

  // Drive cell control; compare straight off the ports at accept
  always_comb begin
    ctrl.cmp       = accept && (operation == tksl_pkg::OP_INSERT);
    ctrl.apply     = (state == tksl_pkg::S_APPLY) && cand_has;
    ctrl.append    = !hit_chain[LIST_DEPTH];
    ctrl.shift_out = (state == tksl_pkg::S_FLUSH);
    ctrl.tag       = (state == tksl_pkg::S_IDLE) ? cand_tag : cand_tag_q;
    ctrl.score     = (state == tksl_pkg::S_IDLE) ? cand_score : cand_score_q;
  end

  // Resolve insert outcome from the end of the scan chain
  always_comb begin
    if (!cand_has) begin
      apply_status = tksl_pkg::ST_COUNTED;
    end else if (ins_chain[LIST_DEPTH]) begin
      apply_status = tksl_pkg::ST_STORED;
    end else if (hit_chain[LIST_DEPTH]) begin
      apply_status = tksl_pkg::ST_DUP;
    end else if (list_full) begin
      apply_status = tksl_pkg::ST_DROPPED;
    end else begin
      apply_status = tksl_pkg::ST_STORED;
    end
  end

  // Next state and busy
  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      tksl_pkg::S_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          if (operation == tksl_pkg::OP_INSERT) begin
            state_next = tksl_pkg::S_APPLY;
          end else if (ent[0].valid) begin
            state_next = tksl_pkg::S_FLUSH;
          end
        end
      end
      tksl_pkg::S_APPLY: begin
        state_next = tksl_pkg::S_IDLE;
      end
      tksl_pkg::S_FLUSH: begin
        if (flush_last) begin
          state_next = tksl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tksl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tksl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Saturating add of the count to the selected total
  always_comb begin
    if (has_candidate && is_spliced) begin
      sum_wide = {1'b0, spliced_total} + {{(tksl_pkg::SUM_W + 1 - tksl_pkg::CNT_W){1'b0}}, add_count};
    end else begin
      sum_wide = {1'b0, unspliced_total} + {{(tksl_pkg::SUM_W + 1 - tksl_pkg::CNT_W){1'b0}}, add_count};
    end
    sum_sat = sum_wide[tksl_pkg::SUM_W] ? '1 : sum_wide[tksl_pkg::SUM_W-1:0];
  end

  // Update totals on insert accept, clear them after the last flushed entry
  always_ff @(posedge clk) begin
    if (rst) begin
      unspliced_total <= '0;
      spliced_total   <= '0;
    end else if (accept && (operation == tksl_pkg::OP_INSERT)) begin
      if (has_candidate && is_spliced) begin
        spliced_total <= sum_sat;
      end else begin
        unspliced_total <= sum_sat;
      end
    end else if ((state == tksl_pkg::S_FLUSH) && flush_last) begin
      unspliced_total <= '0;
      spliced_total   <= '0;
    end
  end

  // Hold the candidate for the apply cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      cand_has     <= has_candidate;
      cand_tag_q   <= cand_tag;
      cand_score_q <= cand_score;
    end
  end

  // Advance the flush rank
  always_ff @(posedge clk) begin
    if (accept) begin
      rank <= '0;
    end else if (state == tksl_pkg::S_FLUSH) begin
      rank <= rank + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (accept && (operation == tksl_pkg::OP_FLUSH) && !ent[0].valid) begin
        strobe        <= 1'b1;
        status        <= tksl_pkg::ST_EMPTY;
        out_tag       <= '0;
        out_score     <= '0;
        out_rank      <= '0;
        unspliced_sum <= unspliced_total;
        spliced_sum   <= spliced_total;
        last          <= 1'b1;
      end else if (state == tksl_pkg::S_APPLY) begin
        strobe        <= 1'b1;
        status        <= apply_status;
        out_tag       <= '0;
        out_score     <= '0;
        out_rank      <= '0;
        unspliced_sum <= unspliced_total;
        spliced_sum   <= spliced_total;
        last          <= 1'b1;
      end else if (state == tksl_pkg::S_FLUSH) begin
        strobe        <= 1'b1;
        status        <= tksl_pkg::ST_FLUSHED;
        out_tag       <= ent[0].tag;
        out_score     <= ent[0].score;
        out_rank      <= rank;
        unspliced_sum <= unspliced_total;
        spliced_sum   <= spliced_total;
        last          <= flush_last;
      end
    end
  end

  // Occupied cells always form a contiguous run from rank 0
  a_valid_run: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + 1'b1)) == '0)
    else $error("list entries not contiguous from rank 0");

  // Final flushed entry leaves an empty list and cleared totals
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == tksl_pkg::S_FLUSH) && flush_last |=>
      (valid_vec == '0) && (unspliced_total == '0) && (spliced_total == '0))
    else $error("flush did not clear list and totals");

  // Only flushed entries may be followed by more results of the same command
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> (status == tksl_pkg::ST_FLUSHED))
    else $error("non-final result outside a flush");

  // Every apply cycle yields exactly one result in the next cycle
  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    (state == tksl_pkg::S_APPLY) |=> strobe && last)
    else $error("apply cycle produced no result");

endmodule
